// File: rtl/lis_pkg.sv
package lis_pkg;

    localparam int MAX_LEN = 1024;
    localparam int DATA_W  = 32;
    localparam int KEY_W   = DATA_W + 1;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int TOL_W   = 8;
    localparam int OUT_TDATA_W = ((CNT_W + 7) / 8) * 8;

    // controller -> datapath
    typedef struct packed {
        logic load;     // take the input word, start a search
        logic probe;    // present probe address to the tail RAM
        logic step;     // compare read tail against key, narrow the window
        logic commit;   // update table and counters, post the result
    } lis_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic n_zero;   // search window is empty
        logic out_free; // result register can take a new word
    } lis_stat_t;

endpackage

// File: rtl/lis_length_tracker.sv
// Running length of the longest strictly increasing subsequence of a stream
// of signed 32-bit samples. Each input word gives one result word with the
// current length, a sticky overflow flag (an append was refused because all
// 1024 tail entries were in use) and tlast copied from the input; after a
// word with tlast set the table length and the flag start again from zero.
// The tolerance is subtracted from each sample before the search, so with
// tolerance 0 equal samples do not extend a run. Each word is handled in
// steps: the word is taken, then each binary-search probe into the tail
// table (at most 11 with a full table) does a registered read of the tail
// RAM and then the compare, the empty search window is seen and the word
// commits. The commit waits while an earlier result still sits unread in
// the output register. The next input word is taken once the previous one
// has committed, while its result may still be waiting in the output
// register. Write tolerance only while no word is in flight.
module lis_length_tracker (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: tolerance [7:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    // s_tdata: value [31:0]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tlast,
    // m_tdata: run_length [10:0], zeros [15:11]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic        m_tlast,
    // m_tuser: overflow [0]
    output logic [0:0]  m_tuser
);

    import lis_pkg::*;

    lis_cmd_t         cmd;
    lis_stat_t        stat;
    logic [CNT_W-1:0] run_length;
    logic             overflow;

    assign cfg_ready = 1'b1;

    lis_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lis_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .in_value       (s_tdata),
        .in_last        (s_tlast),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .out_run_length (run_length),
        .out_done       (m_tlast),
        .out_overflow   (overflow)
    );

    assign m_tdata = {{(OUT_TDATA_W - CNT_W){1'b0}}, run_length};
    assign m_tuser = overflow;

endmodule

// File: rtl/lis_ram.sv
module lis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/lis_ctrl.sv
module lis_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  lis_pkg::lis_stat_t stat,
    output lis_pkg::lis_cmd_t  cmd
);

    import lis_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (stat.n_zero) begin
                    state_next = ST_COMMIT;
                end else begin
                    cmd.probe  = 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                cmd.step   = 1'b1;
                state_next = ST_PROBE;
            end
            ST_COMMIT: begin
                // hold until the previous result word has been taken
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/lis_dp.sv
module lis_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lis_pkg::lis_cmd_t             cmd,
    output lis_pkg::lis_stat_t            stat,
    input  logic [lis_pkg::DATA_W-1:0]    in_value,
    input  logic                          in_last,
    input  logic                          cfg_valid,
    input  logic [lis_pkg::TOL_W-1:0]     cfg_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lis_pkg::CNT_W-1:0]     out_run_length,
    output logic                          out_done,
    output logic                          out_overflow
);

    import lis_pkg::*;

    logic [TOL_W-1:0]         tol_reg;
    logic [DATA_W-1:0]        value_reg;
    logic signed [KEY_W-1:0]  key_reg;
    logic                     last_reg;
    logic [CNT_W-1:0]         lo_reg;
    logic [CNT_W-1:0]         lo_next;
    logic [CNT_W-1:0]         n_reg;
    logic [CNT_W-1:0]         n_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     ovf_reg;
    logic                     ovf_next;
    logic                     m_valid_reg;
    logic [CNT_W-1:0]         out_len_reg;
    logic                     out_done_reg;
    logic                     out_ovf_reg;

    logic [CNT_W-1:0]         half;
    logic [CNT_W-1:0]         probe_sum;
    logic [DATA_W-1:0]        rd_data;
    logic                     tail_less;
    logic                     we;
    logic [ADDR_W-1:0]        waddr;
    logic                     at_end;
    logic                     table_full;
    logic signed [KEY_W-1:0]  key_calc;

    assign half      = n_reg >> 1;
    assign probe_sum = lo_reg + half;
    // full-precision key: sample minus slack, never wraps
    assign key_calc  = $signed({in_value[DATA_W-1], in_value})
                     - $signed({{(KEY_W - TOL_W){1'b0}}, tol_reg});
    assign tail_less = $signed({rd_data[DATA_W-1], rd_data}) < key_reg;

    assign at_end     = (lo_reg >= count_reg);
    assign table_full = (count_reg == CNT_W'(MAX_LEN));
    assign we         = cmd.commit && !(at_end && table_full);
    assign waddr      = lo_reg[ADDR_W-1:0];

    lis_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_LEN)
    ) u_tails (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (value_reg),
        .re    (cmd.probe),
        .raddr (probe_sum[ADDR_W-1:0]),
        .rdata (rd_data)
    );

    always_comb begin
        lo_next    = lo_reg;
        n_next     = n_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.load) begin
            lo_next = '0;
            n_next  = count_reg;
        end
        if (cmd.step) begin
            if (tail_less) begin
                lo_next = probe_sum + CNT_W'(1);
                n_next  = n_reg - half - CNT_W'(1);
            end else begin
                n_next = half;
            end
        end
        if (cmd.commit) begin
            if (at_end) begin
                if (table_full) begin
                    ovf_next = 1'b1;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg     <= '0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                tol_reg <= cfg_data;
            end
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            // sequence closes: report first, then clear
            if (cmd.commit && last_reg) begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end else begin
                count_reg <= count_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg <= lo_next;
        n_reg  <= n_next;
        if (cmd.load) begin
            value_reg <= in_value;
            key_reg   <= key_calc;
            last_reg  <= in_last;
        end
        if (cmd.commit) begin
            out_len_reg  <= count_next;
            out_done_reg <= last_reg;
            out_ovf_reg  <= ovf_next;
        end
    end

    assign stat.n_zero   = (n_reg == '0);
    assign stat.out_free = !m_valid_reg || m_tready;

    assign m_tvalid       = m_valid_reg;
    assign out_run_length = out_len_reg;
    assign out_done       = out_done_reg;
    assign out_overflow   = out_ovf_reg;

endmodule
